[sv/nonstationary_bit_counter_top_defines.svh]
// Assertion macros shared by the nonstationary bit counter RTL.
// No dependencies; included by files that carry assertions.
`ifndef NONSTATIONARY_BIT_COUNTER_TOP_DEFINES_SVH
`define NONSTATIONARY_BIT_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define NBC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nbc assertion failed");

// Next-cycle implication, disabled during reset.
`define NBC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("nbc assertion failed");

`endif

[sv/nbc_pkg.sv]
// Package for the nonstationary bit counter: widths, increment thresholds,
// count ladder and reduction functions. No dependencies.
package nbc_pkg;

   localparam int RANDOM_BITS = 32;
   localparam int COUNT_W     = 8;
   localparam int WEIGHT_W    = 10;

   localparam logic [RANDOM_BITS-1:0] RAND_MASK = {RANDOM_BITS{1'b1}};
   // Increment thresholds for each step size that occurs on the ladder.
   localparam logic [RANDOM_BITS-1:0] THRESH_STEP4  = RAND_MASK / 4;
   localparam logic [RANDOM_BITS-1:0] THRESH_STEP8  = RAND_MASK / 8;
   localparam logic [RANDOM_BITS-1:0] THRESH_STEP31 = RAND_MASK / 31;
   localparam logic [RANDOM_BITS-1:0] THRESH_STEP32 = RAND_MASK / 32;

   // Next representable count above n; 255 stays 255.
   function automatic logic [COUNT_W-1:0] next_up(logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] r;
      if (n < 8'd40)       r = n + 8'd1;
      else if (n < 8'd44)  r = 8'd44;
      else if (n < 8'd48)  r = 8'd48;
      else if (n < 8'd56)  r = 8'd56;
      else if (n < 8'd64)  r = 8'd64;
      else if (n < 8'd96)  r = 8'd96;
      else if (n < 8'd128) r = 8'd128;
      else if (n < 8'd160) r = 8'd160;
      else if (n < 8'd192) r = 8'd192;
      else if (n < 8'd224) r = 8'd224;
      else                 r = 8'd255;
      return r;
   endfunction

   // Threshold the random word must stay below; steps 0 and 1 handled by caller.
   function automatic logic [RANDOM_BITS-1:0] inc_threshold(logic [COUNT_W-1:0] step);
      logic [RANDOM_BITS-1:0] t;
      unique case (step)
         8'd4:    t = THRESH_STEP4;
         8'd8:    t = THRESH_STEP8;
         8'd31:   t = THRESH_STEP31;
         8'd32:   t = THRESH_STEP32;
         default: t = '0;
      endcase
      return t;
   endfunction

   // floor(sqrt(n)) by independent compares against constant squares.
   function automatic logic [3:0] isqrt(logic [COUNT_W-1:0] n);
      logic [3:0] r;
      r = '0;
      for (int k = 1; k < 16; k++) begin
         if (n >= COUNT_W'(k * k)) r = 4'(k);
      end
      return r;
   endfunction

   // Reduction of the opposite count; results are all below 40, so on the ladder.
   function automatic logic [COUNT_W-1:0] shrink(logic [COUNT_W-1:0] n);
      logic [COUNT_W-1:0] r;
      if (n < 8'd2)       r = n;
      else if (n < 8'd25) r = {1'b0, n[COUNT_W-1:1]};
      else                r = COUNT_W'(isqrt(n)) + 8'd6;
      return r;
   endfunction

endpackage

[sv/nonstationary_bit_counter_top.sv]
// Each accepted request passes through the UPDATE, DIVIDE and FINISH states before its
// result is registered; a new request is taken only in IDLE, once the 8-step restoring
// divider that forms the weight ratio has finished and the result has been stored.
// req_stall is high while an item is in progress or its result cannot be stored.
// Reset (synchronous): both counts go to zero, sequencer idle, no result pending.
// Depends on nbc_pkg and nonstationary_bit_counter_top_defines.svh.
`include "nonstationary_bit_counter_top_defines.svh"

module nonstationary_bit_counter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_bit_req,
   input  logic [31:0]                       req_random_word,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nbc_pkg::COUNT_W-1:0]       rsp_new_count0,
   output logic [nbc_pkg::COUNT_W-1:0]       rsp_new_count1,
   output logic [nbc_pkg::WEIGHT_W-1:0]      rsp_weight0,
   output logic [nbc_pkg::WEIGHT_W-1:0]      rsp_weight1,
   output logic                              rsp_incremented
);

   typedef enum logic [1:0] {IDLE, UPDATE, DIVIDE, FINISH} state_type;

   state_type                          state_ff, state_in;
   logic [nbc_pkg::COUNT_W-1:0]        count0_ff, count0_in;
   logic [nbc_pkg::COUNT_W-1:0]        count1_ff, count1_in;
   logic                               bit_ff, bit_in;
   logic [nbc_pkg::RANDOM_BITS-1:0]    rnd_ff, rnd_in;
   logic                               ok_ff, ok_in;
   logic [nbc_pkg::COUNT_W-1:0]        div_rem_ff, div_rem_in;
   logic [nbc_pkg::COUNT_W-1:0]        div_quot_ff, div_quot_in;
   logic [nbc_pkg::COUNT_W-1:0]        div_den_ff, div_den_in;
   logic [2:0]                         div_cnt_ff, div_cnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [nbc_pkg::COUNT_W-1:0]        rsp_count0_ff, rsp_count0_in;
   logic [nbc_pkg::COUNT_W-1:0]        rsp_count1_ff, rsp_count1_in;
   logic [nbc_pkg::WEIGHT_W-1:0]       rsp_weight0_ff, rsp_weight0_in;
   logic [nbc_pkg::WEIGHT_W-1:0]       rsp_weight1_ff, rsp_weight1_in;
   logic                               rsp_inc_ff, rsp_inc_in;

   logic                               req_accept;
   logic                               rsp_free;
   logic [nbc_pkg::COUNT_W-1:0]        sel_cnt, other_cnt, target, step;
   logic [nbc_pkg::COUNT_W-1:0]        sel_new, other_new, new0, new1;
   logic                               inc_ok;
   logic [nbc_pkg::COUNT_W:0]          partial, diff;
   logic                               div_ge;
   logic [nbc_pkg::WEIGHT_W-1:0]       quot_ext;

   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Count update, evaluated in the UPDATE cycle
   always_comb begin
      sel_cnt   = bit_ff ? count1_ff : count0_ff;
      other_cnt = bit_ff ? count0_ff : count1_ff;
      target    = nbc_pkg::next_up(sel_cnt);
      step      = target - sel_cnt;
      if (step == 8'd0)      inc_ok = 1'b0;
      else if (step == 8'd1) inc_ok = 1'b1;
      else                   inc_ok = rnd_ff < nbc_pkg::inc_threshold(step);
      sel_new   = inc_ok ? target : sel_cnt;
      other_new = nbc_pkg::shrink(other_cnt);
      new0      = bit_ff ? other_new : sel_new;
      new1      = bit_ff ? sel_new : other_new;
   end

   // Restoring divider step used in DIVIDE: one quotient bit per cycle
   always_comb begin
      partial = {div_rem_ff, div_quot_ff[nbc_pkg::COUNT_W-1]};
      diff    = partial - {1'b0, div_den_ff};
      div_ge  = (partial >= {1'b0, div_den_ff});
   end

   assign quot_ext = nbc_pkg::WEIGHT_W'(div_quot_ff);

   always_comb begin
      state_in       = state_ff;
      count0_in      = count0_ff;
      count1_in      = count1_ff;
      bit_in         = bit_ff;
      rnd_in         = rnd_ff;
      ok_in          = ok_ff;
      div_rem_in     = div_rem_ff;
      div_quot_in    = div_quot_ff;
      div_den_in     = div_den_ff;
      div_cnt_in     = div_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_count0_in  = rsp_count0_ff;
      rsp_count1_in  = rsp_count1_ff;
      rsp_weight0_in = rsp_weight0_ff;
      rsp_weight1_in = rsp_weight1_ff;
      rsp_inc_in     = rsp_inc_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_accept) begin
               bit_in   = req_bit_req;
               rnd_in   = req_random_word[nbc_pkg::RANDOM_BITS-1:0];
               state_in = UPDATE;
            end
         end
         UPDATE: begin
            count0_in  = new0;
            count1_in  = new1;
            ok_in      = inc_ok;
            // larger over smaller; result unused when either is zero or equal
            div_quot_in = (new0 > new1) ? new0 : new1;
            div_den_in  = (new0 > new1) ? new1 : new0;
            div_rem_in  = '0;
            div_cnt_in  = '0;
            state_in    = DIVIDE;
         end
         DIVIDE: begin
            div_rem_in  = div_ge ? diff[nbc_pkg::COUNT_W-1:0]
                                 : partial[nbc_pkg::COUNT_W-1:0];
            div_quot_in = {div_quot_ff[nbc_pkg::COUNT_W-2:0], div_ge};
            div_cnt_in  = div_cnt_ff + 3'd1;
            if (div_cnt_ff == 3'd7) state_in = FINISH;
         end
         FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_count0_in = count0_ff;
               rsp_count1_in = count1_ff;
               rsp_inc_in    = ok_ff;
               if (count0_ff == '0) begin
                  rsp_weight0_in = '0;
                  rsp_weight1_in = {count1_ff, 2'b00};
               end else if (count1_ff == '0) begin
                  rsp_weight0_in = {count0_ff, 2'b00};
                  rsp_weight1_in = '0;
               end else if (count0_ff > count1_ff) begin
                  rsp_weight0_in = quot_ext;
                  rsp_weight1_in = 10'd1;
               end else if (count1_ff > count0_ff) begin
                  rsp_weight0_in = 10'd1;
                  rsp_weight1_in = quot_ext;
               end else begin
                  rsp_weight0_in = 10'd1;
                  rsp_weight1_in = 10'd1;
               end
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         count0_ff    <= '0;
         count1_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count0_ff    <= count0_in;
         count1_ff    <= count1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bit_ff         <= bit_in;
      rnd_ff         <= rnd_in;
      ok_ff          <= ok_in;
      div_rem_ff     <= div_rem_in;
      div_quot_ff    <= div_quot_in;
      div_den_ff     <= div_den_in;
      div_cnt_ff     <= div_cnt_in;
      rsp_count0_ff  <= rsp_count0_in;
      rsp_count1_ff  <= rsp_count1_in;
      rsp_weight0_ff <= rsp_weight0_in;
      rsp_weight1_ff <= rsp_weight1_in;
      rsp_inc_ff     <= rsp_inc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_count0  = rsp_count0_ff;
   assign rsp_new_count1  = rsp_count1_ff;
   assign rsp_weight0     = rsp_weight0_ff;
   assign rsp_weight1     = rsp_weight1_ff;
   assign rsp_incremented = rsp_inc_ff;

   `NBC_ASSERT_NEXT(a_accept_starts_update, req_accept, state_ff == UPDATE)
   `NBC_ASSERT_NOW(a_div_remainder_below_divisor, (state_ff == FINISH) && (div_den_ff != '0), div_rem_ff < div_den_ff)
   `NBC_ASSERT_NOW(a_ratio_weight_one, rsp_valid && (rsp_new_count0 != '0) && (rsp_new_count1 != '0), (rsp_weight0 == 10'd1) || (rsp_weight1 == 10'd1))

endmodule

[tb/tb_nonstationary_bit_counter_top.sv]
// Testbench for nonstationary_bit_counter_top: directed and random bit/word
// transactions, checked against a count/weight predictor inside the bench.
// Depends on nbc_pkg and the nonstationary_bit_counter_top RTL.
module tb_nonstationary_bit_counter_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL_ITEMS = 1100;
   localparam int STEADY_TAIL = 150;
   localparam int DRAIN_POINT = 400;
   localparam int REPORT_MAX  = 10;
   localparam longint unsigned WORD_MASK = (64'd1 << nbc_pkg::RANDOM_BITS) - 64'd1;

   typedef struct packed {
      logic [nbc_pkg::COUNT_W-1:0]  count0;
      logic [nbc_pkg::COUNT_W-1:0]  count1;
      logic [nbc_pkg::WEIGHT_W-1:0] weight0;
      logic [nbc_pkg::WEIGHT_W-1:0] weight1;
      logic                         incremented;
   } count_update_type;

   typedef struct {
      logic             bit_in;
      logic [31:0]      word;
      count_update_type outcome;
      bit               drain_first;
      bit               steady;
   } bit_txn_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic                         req_bit_req = 1'b0;
   logic [31:0]                  req_random_word = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [nbc_pkg::COUNT_W-1:0]  rsp_new_count0;
   logic [nbc_pkg::COUNT_W-1:0]  rsp_new_count1;
   logic [nbc_pkg::WEIGHT_W-1:0] rsp_weight0;
   logic [nbc_pkg::WEIGHT_W-1:0] rsp_weight1;
   logic                         rsp_incremented;

   bit_txn_type      pending_q[$];
   count_update_type update_q[$];
   bit_txn_type      cur_txn;
   logic [nbc_pkg::COUNT_W-1:0] pred_count0 = '0;
   logic [nbc_pkg::COUNT_W-1:0] pred_count1 = '0;
   bit holding = 1'b0;
   bit req_taken = 1'b0;
   bit quiet = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int mismatches = 0;

   nonstationary_bit_counter_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_bit_req     (req_bit_req),
      .req_random_word (req_random_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_new_count0  (rsp_new_count0),
      .rsp_new_count1  (rsp_new_count1),
      .rsp_weight0     (rsp_weight0),
      .rsp_weight1     (rsp_weight1),
      .rsp_incremented (rsp_incremented)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Next count on the ladder: exact below 40, then steps of 4, 8, 32, top at 255.
   function automatic logic [nbc_pkg::COUNT_W-1:0] ladder_above(
         logic [nbc_pkg::COUNT_W-1:0] n);
      if (n < 40) return n + 8'd1;
      if (n < 48) return (n & 8'hfc) + 8'd4;
      if (n < 64) return (n & 8'hf8) + 8'd8;
      if (n < 224) return (n & 8'he0) + 8'd32;
      return 8'd255;
   endfunction

   function automatic logic [nbc_pkg::COUNT_W-1:0] round_to_rung(int n);
      if (n < 40) return nbc_pkg::COUNT_W'(n);
      if (n < 48) return nbc_pkg::COUNT_W'(n & ~3);
      if (n < 64) return nbc_pkg::COUNT_W'(n & ~7);
      if (n < 255) return nbc_pkg::COUNT_W'(n & ~31);
      return 8'd255;
   endfunction

   function automatic logic [nbc_pkg::COUNT_W-1:0] decay_count(
         logic [nbc_pkg::COUNT_W-1:0] n);
      int r;
      r = 0;
      if (n < 2) return n;
      if (n < 25) return round_to_rung(n / 2);
      while ((r + 1) * (r + 1) <= n) r++;
      return round_to_rung(r + 6);
   endfunction

   // Word must stay below this for a step larger than one to succeed.
   function automatic longint unsigned success_limit(logic [nbc_pkg::COUNT_W-1:0] c);
      return WORD_MASK / longint'(ladder_above(c) - c);
   endfunction

   function automatic count_update_type predict_update(logic b, logic [31:0] word);
      logic [nbc_pkg::COUNT_W-1:0] hit;
      logic [nbc_pkg::COUNT_W-1:0] miss;
      logic [nbc_pkg::COUNT_W-1:0] target;
      longint unsigned rnd;
      int n0, n1, w0, w1;
      count_update_type res;
      rnd = longint'(word) & WORD_MASK;
      hit = b ? pred_count1 : pred_count0;
      miss = b ? pred_count0 : pred_count1;
      target = ladder_above(hit);
      if (target == hit) res.incremented = 1'b0;
      else if (target - hit == 8'd1) res.incremented = 1'b1;
      else res.incremented = (rnd < success_limit(hit));
      if (res.incremented) hit = target;
      miss = decay_count(miss);
      if (b) begin
         pred_count1 = hit;
         pred_count0 = miss;
      end else begin
         pred_count0 = hit;
         pred_count1 = miss;
      end
      n0 = pred_count0;
      n1 = pred_count1;
      w0 = 2 * n0;
      w1 = 2 * n1;
      if (n0 == 0) w1 = 2 * w1;
      else if (n1 == 0) w0 = 2 * w0;
      else if (n0 > n1) begin
         w0 = w0 / w1;
         w1 = 1;
      end else if (n1 > n0) begin
         w1 = w1 / w0;
         w0 = 1;
      end else begin
         w0 = 1;
         w1 = 1;
      end
      res.count0 = pred_count0;
      res.count1 = pred_count1;
      res.weight0 = nbc_pkg::WEIGHT_W'(w0);
      res.weight1 = nbc_pkg::WEIGHT_W'(w1);
      return res;
   endfunction

   task automatic queue_txn(logic b, logic [31:0] word, bit drain, bit steady);
      bit_txn_type t;
      t.bit_in = b;
      t.word = word;
      t.drain_first = drain;
      t.steady = steady;
      t.outcome = predict_update(b, word);
      pending_q = {pending_q, t};
   endtask

   // Mix of random words, all ones, words at the success boundary and small words.
   function automatic logic [31:0] pick_word(logic b);
      logic [nbc_pkg::COUNT_W-1:0] c;
      longint unsigned lim;
      c = b ? pred_count1 : pred_count0;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4: return 32'hffff_ffff;
         5, 6: begin
            if (ladder_above(c) - c < 2) return $urandom();
            lim = success_limit(c);
            return 32'($urandom_range(0, 1) ? lim : lim - 1);
         end
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   task automatic report_mismatch(string what, count_update_type want,
                                  count_update_type got);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("%0t: %s: expected n0=%0d n1=%0d w0=%0d w1=%0d inc=%0b, ",
                  $time, what, want.count0, want.count1, want.weight0, want.weight1,
                  want.incremented,
                  "got n0=%0d n1=%0d w0=%0d w1=%0d inc=%0b",
                  got.count0, got.count1, got.weight0, got.weight1,
                  got.incremented);
   endtask

   // Driver: one transaction at a time, random gaps between them.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            req_taken = 1'b0;
            holding = 1'b0;
         end
         if (!holding) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() == 0 ||
                         (pending_q[0].drain_first && update_q.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               cur_txn = pending_q.pop_front();
               req_bit_req <= cur_txn.bit_in;
               req_random_word <= cur_txn.word;
               req_valid <= 1'b1;
               holding = 1'b1;
               quiet = cur_txn.steady;
               if (!cur_txn.steady && $urandom_range(0, 4) == 0)
                  gap_left = $urandom_range(1, 13);
            end
         end
      end
   end

   // Result-side backpressure bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!quiet && !reset && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 12);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check results first, then record the transaction accepted at this edge.
   always @(posedge clock) begin
      count_update_type got;
      count_update_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.count0 = rsp_new_count0;
            got.count1 = rsp_new_count1;
            got.weight0 = rsp_weight0;
            got.weight1 = rsp_weight1;
            got.incremented = rsp_incremented;
            if (update_q.size() == 0) begin
               report_mismatch("unexpected result", '0, got);
            end else begin
               want = update_q.pop_front();
               if (got.count0 !== want.count0 || got.count1 !== want.count1 ||
                   got.weight0 !== want.weight0 || got.weight1 !== want.weight1 ||
                   got.incremented !== want.incremented)
                  report_mismatch("result mismatch", want, got);
            end
         end
         if (req_valid && !req_stall) begin
            update_q = {update_q, cur_txn.outcome};
            req_taken = 1'b1;
         end
      end
   end

   initial begin
      logic b;
      bit climb;
      int run;
      int wait_cycles;
      // directed: zero-count weight cases, equal counts, both orderings, word extremes
      queue_txn(1'b0, 32'h0000_0000, 1'b0, 1'b0);
      queue_txn(1'b0, 32'hffff_ffff, 1'b0, 1'b0);
      queue_txn(1'b1, 32'hffff_ffff, 1'b0, 1'b0);
      queue_txn(1'b1, 32'ha5a5_a5a5, 1'b0, 1'b0);
      queue_txn(1'b1, 32'h5a5a_5a5a, 1'b0, 1'b0);
      queue_txn(1'b1, 32'h0000_0001, 1'b0, 1'b0);
      queue_txn(1'b1, 32'h8000_0000, 1'b0, 1'b0);
      for (int k = 0; k < 8; k++)
         queue_txn(1'b0, $urandom(), 1'b0, 1'b0);
      queue_txn(1'b1, 32'hffff_ffff, 1'b0, 1'b0);
      queue_txn(1'b1, 32'h0000_0000, 1'b0, 1'b0);
      // random runs; climbing runs push a count up the ladder, to its top (255) in the longer runs
      while (pending_q.size() < TOTAL_ITEMS) begin
         b = 1'($urandom_range(0, 1));
         climb = ($urandom_range(0, 3) == 0);
         run = climb ? $urandom_range(45, 70) : $urandom_range(1, 30);
         for (int k = 0; k < run && pending_q.size() < TOTAL_ITEMS; k++)
            queue_txn(b, climb ? 32'h0 : pick_word(b),
                      pending_q.size() == DRAIN_POINT || $urandom_range(0, 199) == 0,
                      pending_q.size() >= TOTAL_ITEMS - STEADY_TAIL);
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_q.size() != 0 || holding) @(posedge clock);
      wait_cycles = 0;
      while (update_q.size() != 0 && wait_cycles < 3000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (15) @(posedge clock);
      if (mismatches == 0 && update_q.size() == 0) begin
         $display("** nonstationary_bit_counter_top: PASSED **");
      end else begin
         if (update_q.size() != 0)
            $display("%0d expected results never arrived", update_q.size());
         $display("** nonstationary_bit_counter_top: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout waiting for results");
      $display("** nonstationary_bit_counter_top: FAILED **");
      $finish;
   end

endmodule
